// ===== hw/rtl/pid_controller_filtered_derivative_core_assert.svh =====
// Assertion macros shared by the controller RTL.
// Each use expects a clock named clk and an active-high reset named rst in scope.
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_CORE_ASSERT_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Implication into the same cycle.
`define PCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle.
`define PCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCFD_ASSERT_NOW(lbl, ante, cons, msg)
`define PCFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/pcfd_pkg.sv =====
`default_nettype none
package pcfd_pkg;

  localparam int SIG_W   = 32;  // Q16.16 signals and Q8.24 gains
  localparam int ERR_W   = 33;
  localparam int DIF_W   = 34;
  localparam int TERM_W  = 40;  // Q24.16 internal terms
  localparam int SUM_W   = 43;
  localparam int ALPHA_W = 17;
  localparam int MA_W    = 41;  // shared multiplier operand A
  localparam int MB_W    = 18;  // shared multiplier operand B
  localparam int PROD_W  = MA_W + MB_W;
  localparam int PART_W  = PROD_W - 16;
  localparam int SAT_W   = 60;
  localparam int IDX_W   = 3;
  localparam int FLAG_W  = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INT_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DER_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_LOW    = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_HIGH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_BIAS   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SMOOTHING  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DIFF_MEAS  = 3'd7;

  localparam logic [FLAG_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [FLAG_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [FLAG_W-1:0] CLAMP_LOW  = 2'd2;

  typedef struct packed {
    logic signed [SIG_W-1:0] prop_gain;
    logic signed [SIG_W-1:0] integral_gain;
    logic signed [SIG_W-1:0] derivative_gain;
    logic signed [SIG_W-1:0] output_low;
    logic signed [SIG_W-1:0] output_high;
    logic signed [SIG_W-1:0] output_bias;
    logic [ALPHA_W-1:0]      smoothing;
    logic                    diff_on_meas;
  } cfg_t;

  // Saturate a wide signed value to the 40-bit term range.
  function automatic logic signed [TERM_W-1:0] sat40(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-TERM_W:0] upper;
    logic signed [TERM_W-1:0] res;
    upper = x[SAT_W-1:TERM_W-1];
    if ((&upper) || !(|upper)) begin
      res = x[TERM_W-1:0];
    end else if (x[SAT_W-1]) begin
      res = {1'b1, {(TERM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(TERM_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pcfd_cfg.sv =====
`default_nettype none
module pcfd_cfg import pcfd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [SIG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= '0;
      cfg.integral_gain   <= '0;
      cfg.derivative_gain <= '0;
      cfg.output_low      <= {1'b1, {(SIG_W-1){1'b0}}};
      cfg.output_high     <= {1'b0, {(SIG_W-1){1'b1}}};
      cfg.output_bias     <= '0;
      cfg.smoothing       <= ALPHA_ONE;
      cfg.diff_on_meas    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN: cfg.prop_gain       <= cfg_data;
        REG_INT_GAIN:  cfg.integral_gain   <= cfg_data;
        REG_DER_GAIN:  cfg.derivative_gain <= cfg_data;
        REG_OUT_LOW:   cfg.output_low      <= cfg_data;
        REG_OUT_HIGH:  cfg.output_high     <= cfg_data;
        REG_OUT_BIAS:  cfg.output_bias     <= cfg_data;
        REG_SMOOTHING: cfg.smoothing       <= cfg_data[ALPHA_W-1:0];
        REG_DIFF_MEAS: cfg.diff_on_meas    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pcfd_mul.sv =====
`default_nettype none
module pcfd_mul import pcfd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MA_W-1:0]   a,
  input  wire logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0]      prod
);

  // One signed multiply per cycle, product registered.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pid_controller_filtered_derivative_core.sv =====
`default_nettype none
`include "pid_controller_filtered_derivative_core_assert.svh"
// PID controller with clamped output, conditional integration and a low-pass
// filtered derivative. On its way from acceptance to the result register each
// sample makes seven passes through one shared 41x18 multiplier (two
// partial products for each of the P, I and D gain products, one for the
// derivative filter) plus the adds and the clamp. sample_stall is high while
// a sample is in work and while a finished result waits for the result
// register to free; a new sample is accepted while the previous result still
// waits to be taken. Configuration writes are registered and must be made
// only while no sample is in flight.
module pid_controller_filtered_derivative_core import pcfd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    sample_valid,
  output logic                         sample_stall,
  input  wire logic signed [SIG_W-1:0] target,
  input  wire logic signed [SIG_W-1:0] sensed,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic signed [SIG_W-1:0]      drive,
  output logic [FLAG_W-1:0]            clamp_state,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [SIG_W-1:0]        cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P_LO = 4'd1;
  localparam logic [3:0] S_P_HI = 4'd2;
  localparam logic [3:0] S_I_LO = 4'd3;
  localparam logic [3:0] S_I_HI = 4'd4;
  localparam logic [3:0] S_D_LO = 4'd5;
  localparam logic [3:0] S_D_HI = 4'd6;
  localparam logic [3:0] S_F0   = 4'd7;
  localparam logic [3:0] S_F1   = 4'd8;
  localparam logic [3:0] S_F2   = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  cfg_t cfg;

  pcfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [3:0] state;
  logic [3:0] state_next;

  logic primed;
  logic signed [ERR_W-1:0]  err;
  logic signed [SIG_W-1:0]  meas;
  logic signed [DIF_W-1:0]  dop;
  logic signed [TERM_W-1:0] integral_acc;
  logic signed [ERR_W-1:0]  last_error;
  logic signed [SIG_W-1:0]  last_sensed;
  logic signed [TERM_W-1:0] last_deriv;
  logic signed [PART_W-1:0] part;
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] istep;
  logic signed [TERM_W-1:0] new_int;
  logic signed [TERM_W-1:0] draw;
  logic signed [TERM_W-1:0] d_term;
  logic signed [SUM_W-1:0]  sum;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  pcfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic sample_take;
  logic result_take;
  logic out_load;

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign result_take  = result_valid && !result_stall;
  assign out_load     = (state == S_OUT) && (!result_valid || !result_stall);

  logic signed [ERR_W-1:0] err_in;
  assign err_in = $signed({target[SIG_W-1], target}) - $signed({sensed[SIG_W-1], sensed});

  logic signed [DIF_W-1:0] err_x;
  assign err_x = {err[ERR_W-1], err};

  logic [ALPHA_W-1:0] alpha;
  assign alpha = (cfg.smoothing > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P_LO: begin
        mul_a = {{(MA_W-SIG_W){cfg.prop_gain[SIG_W-1]}}, cfg.prop_gain};
        mul_b = {2'b00, err_x[15:0]};
      end
      S_P_HI: begin
        mul_a = {{(MA_W-SIG_W){cfg.prop_gain[SIG_W-1]}}, cfg.prop_gain};
        mul_b = err_x[DIF_W-1:16];
      end
      S_I_LO: begin
        mul_a = {{(MA_W-SIG_W){cfg.integral_gain[SIG_W-1]}}, cfg.integral_gain};
        mul_b = {2'b00, err_x[15:0]};
      end
      S_I_HI: begin
        mul_a = {{(MA_W-SIG_W){cfg.integral_gain[SIG_W-1]}}, cfg.integral_gain};
        mul_b = err_x[DIF_W-1:16];
      end
      S_D_LO: begin
        mul_a = {{(MA_W-SIG_W){cfg.derivative_gain[SIG_W-1]}}, cfg.derivative_gain};
        mul_b = {2'b00, dop[15:0]};
      end
      S_D_HI: begin
        mul_a = {{(MA_W-SIG_W){cfg.derivative_gain[SIG_W-1]}}, cfg.derivative_gain};
        mul_b = dop[DIF_W-1:16];
      end
      S_F1: begin
        mul_a = $signed({draw[TERM_W-1], draw}) - $signed({last_deriv[TERM_W-1], last_deriv});
        mul_b = {1'b0, alpha};
      end
      default: ;
    endcase
  end

  // High partial product plus the floored low one, then floor by 2^8.
  logic signed [PROD_W-1:0] mq_sum;
  logic signed [TERM_W-1:0] mq;
  assign mq_sum = prod + {{(PROD_W-PART_W){part[PART_W-1]}}, part};
  assign mq     = sat40({{(SAT_W-PROD_W+8){mq_sum[PROD_W-1]}}, mq_sum[PROD_W-1:8]});

  logic signed [TERM_W:0] int_sum;
  assign int_sum = $signed({integral_acc[TERM_W-1], integral_acc})
                 + $signed({istep[TERM_W-1], istep});

  logic signed [TERM_W+3:0] filt_sum;
  assign filt_sum = $signed({{4{last_deriv[TERM_W-1]}}, last_deriv})
                  + $signed({prod[PROD_W-1], prod[PROD_W-1:16]});

  logic signed [SUM_W-1:0] high_x;
  logic signed [SUM_W-1:0] low_x;
  assign high_x = {{(SUM_W-SIG_W){cfg.output_high[SIG_W-1]}}, cfg.output_high};
  assign low_x  = {{(SUM_W-SIG_W){cfg.output_low[SIG_W-1]}}, cfg.output_low};

  logic signed [SIG_W-1:0] drive_next;
  logic [FLAG_W-1:0]       flag_next;
  logic                    keep_int;

  always_comb begin
    if (sum > high_x) begin
      drive_next = cfg.output_high;
      flag_next  = CLAMP_HIGH;
      keep_int   = err[ERR_W-1];
    end else if (sum < low_x) begin
      drive_next = cfg.output_low;
      flag_next  = CLAMP_LOW;
      keep_int   = !err[ERR_W-1] && (err != '0);
    end else begin
      drive_next = sum[SIG_W-1:0];
      flag_next  = CLAMP_NONE;
      keep_int   = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sample_take) state_next = S_P_LO;
      S_P_LO:  state_next = S_P_HI;
      S_P_HI:  state_next = S_I_LO;
      S_I_LO:  state_next = S_I_HI;
      S_I_HI:  state_next = S_D_LO;
      S_D_LO:  state_next = S_D_HI;
      S_D_HI:  state_next = S_F0;
      S_F0:    state_next = S_F1;
      S_F1:    state_next = S_F2;
      S_F2:    state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      result_valid <= 1'b0;
      integral_acc <= '0;
      last_error   <= '0;
      last_sensed  <= '0;
      last_deriv   <= '0;
    end else begin
      state <= state_next;
      if (sample_take && !primed) begin
        // seed history so the first derivative is zero
        last_error  <= err_in;
        last_sensed <= sensed;
        primed      <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
        if (keep_int) integral_acc <= new_int;
        last_error  <= err;
        last_sensed <= meas;
        last_deriv  <= d_term;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      err  <= err_in;
      meas <= sensed;
    end
    if (out_load) begin
      drive       <= drive_next;
      clamp_state <= flag_next;
    end
    unique case (state)
      S_P_LO: begin
        if (cfg.diff_on_meas) begin
          dop <= $signed({{2{last_sensed[SIG_W-1]}}, last_sensed})
               - $signed({{2{meas[SIG_W-1]}}, meas});
        end else begin
          dop <= err_x - $signed({last_error[ERR_W-1], last_error});
        end
      end
      S_P_HI, S_I_HI, S_D_HI: part <= prod[PROD_W-1:16];
      S_I_LO: p_term <= mq;
      S_D_LO: istep  <= mq;
      S_F0: begin
        draw <= mq;
        sum  <= $signed({{(SUM_W-SIG_W){cfg.output_bias[SIG_W-1]}}, cfg.output_bias})
              + $signed({{(SUM_W-TERM_W){p_term[TERM_W-1]}}, p_term});
      end
      S_F1: sum <= sum + $signed({{(SUM_W-TERM_W){new_int[TERM_W-1]}}, new_int});
      S_F2: d_term <= sat40({{(SAT_W-TERM_W-4){filt_sum[TERM_W+3]}}, filt_sum});
      S_SUM: sum <= sum + $signed({{(SUM_W-TERM_W){d_term[TERM_W-1]}}, d_term});
      default: ;
    endcase
    if (state == S_D_HI) begin
      new_int <= sat40({{(SAT_W-TERM_W-1){int_sum[TERM_W]}}, int_sum});
    end
  end

  `PCFD_ASSERT_NEXT(a_primed_after_sample, sample_take, primed, "sample taken but history not seeded")
  `PCFD_ASSERT_NEXT(a_result_loaded, out_load, result_valid, "result register not loaded")
  `PCFD_ASSERT_NEXT(a_result_drained, result_take && !out_load, !result_valid, "taken result still valid")
  `PCFD_ASSERT_NEXT(a_integral_hold, !out_load, $stable(integral_acc), "integral changed outside result load")

endmodule
`default_nettype wire
